// ===== rtl/cfa_pkg.sv =====
// Shared types, constants and codes of the contiguous fit allocator.
`timescale 1ns / 1ps
package cfa_pkg;

  // Table geometry
  localparam int MAX_SEGMENTS = 32;
  localparam int NUM_CELLS    = MAX_SEGMENTS + 1;
  localparam int IDX_W        = $clog2(NUM_CELLS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int AGE_W        = $clog2(MAX_SEGMENTS);
  localparam int ADDR_W       = 12;
  localparam int ID_W         = 8;
  localparam int HOLE_W       = 6;

  localparam logic [ADDR_W-1:0] MEMORY_RESET = 12'd128;

  // Placement policies
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  // Result outcomes
  localparam logic [1:0] OUT_PLACED   = 2'd0;
  localparam logic [1:0] OUT_EVICTED  = 2'd1;
  localparam logic [1:0] OUT_REJECTED = 2'd2;

  // Register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_MEMSIZE = 1'b1;

  // Cell operations
  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_SHIFT  = 3'd4;

  // One resident segment
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic [ID_W-1:0]   owner;
    logic [AGE_W-1:0]  age;
  } seg_t;

  // One position of the scan line
  typedef struct packed {
    logic              is_seg;
    logic              gap_ok;
    logic              victim;
    logic [ADDR_W-1:0] gap_start;
    logic [ADDR_W-1:0] gap_len;
    logic [ADDR_W-1:0] seg_base;
    logic [ADDR_W-1:0] seg_len;
    logic [ID_W-1:0]   seg_owner;
  } tap_t;

  // Broadcast control for every cell
  typedef struct packed {
    logic [2:0]        op;
    logic [IDX_W-1:0]  slot;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] mem_size;
    seg_t              new_seg;
  } ctrl_t;

  // Outcome of one scan
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] start;
    logic [IDX_W-1:0]  slot;
    logic [HOLE_W-1:0] hidx;
    logic [HOLE_W-1:0] holes;
    logic [IDX_W-1:0]  victim_slot;
    logic [ID_W-1:0]   victim_owner;
    logic [ADDR_W-1:0] victim_base;
    logic [ADDR_W-1:0] victim_len;
  } sel_t;

endpackage

// ===== rtl/cfa_cell.sv =====
// One segment cell: holds a segment, its load age and a scan line position.
`timescale 1ns / 1ps
module cfa_cell
  import cfa_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  ctrl_t            ctrl,
  input  seg_t             left_seg,
  input  seg_t             right_seg,
  input  tap_t             right_tap,
  output seg_t             seg_q,
  output tap_t             tap_q
);

  seg_t seg_r, seg_nxt;
  tap_t tap_r, tap_nxt;
  logic [ADDR_W:0] prev_end;
  logic [ADDR_W:0] limit;

  assign seg_q = seg_r;
  assign tap_q = tap_r;

  // End of the left neighbor is where the gap before this cell starts
  assign prev_end = {1'b0, left_seg.base} + {1'b0, left_seg.len};

  // Update the segment on insert or remove
  always_comb begin
    seg_nxt = seg_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (cell_idx > ctrl.slot) begin
          seg_nxt = left_seg;
        end else if (cell_idx == ctrl.slot) begin
          seg_nxt = ctrl.new_seg;
        end
      end
      OP_REMOVE: begin
        if (cell_idx >= ctrl.slot) begin
          seg_nxt = right_seg;
        end
        seg_nxt.age = seg_nxt.age - AGE_W'(1);
      end
      default: seg_nxt = seg_r;
    endcase
  end

  // Form this position's gap, or shift the scan line toward cell zero
  always_comb begin
    tap_nxt = tap_r;
    limit   = (cell_idx < IDX_W'(ctrl.count)) ? {1'b0, seg_r.base} : {1'b0, ctrl.mem_size};
    unique case (ctrl.op)
      OP_LOAD: begin
        tap_nxt.is_seg    = cell_idx < IDX_W'(ctrl.count);
        tap_nxt.gap_ok    = (cell_idx <= IDX_W'(ctrl.count)) && (limit > prev_end);
        tap_nxt.victim    = seg_r.age == '0;
        tap_nxt.gap_start = prev_end[ADDR_W-1:0];
        tap_nxt.gap_len   = limit[ADDR_W-1:0] - prev_end[ADDR_W-1:0];
        tap_nxt.seg_base  = seg_r.base;
        tap_nxt.seg_len   = seg_r.len;
        tap_nxt.seg_owner = seg_r.owner;
      end
      OP_SHIFT: tap_nxt = right_tap;
      default:  tap_nxt = tap_r;
    endcase
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
    tap_r <= tap_nxt;
  end

endmodule

// ===== rtl/cfa_select.sv =====
// Hole selector: walks the scan line one position a cycle while stepped and keeps the pick.
`timescale 1ns / 1ps
module cfa_select
  import cfa_pkg::*;
(
  input  logic              clk,
  input  logic              start,
  input  logic              step,
  input  logic [1:0]        policy,
  input  logic [ADDR_W-1:0] need,
  input  logic [HOLE_W-1:0] rover,
  input  tap_t              tap,
  output sel_t              res
);

  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [HOLE_W-1:0] hidx_r, hidx_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] pstart_r, pstart_nxt;
  logic [ADDR_W-1:0] plen_r, plen_nxt;
  logic [IDX_W-1:0]  pslot_r, pslot_nxt;
  logic [HOLE_W-1:0] phidx_r, phidx_nxt;
  logic              wfound_r, wfound_nxt;
  logic [ADDR_W-1:0] wstart_r, wstart_nxt;
  logic [IDX_W-1:0]  wslot_r, wslot_nxt;
  logic [HOLE_W-1:0] whidx_r, whidx_nxt;
  logic [IDX_W-1:0]  vslot_r, vslot_nxt;
  logic [ID_W-1:0]   vowner_r, vowner_nxt;
  logic [ADDR_W-1:0] vbase_r, vbase_nxt;
  logic [ADDR_W-1:0] vlen_r, vlen_nxt;
  logic              fits, take, take_wrap;

  // Decide whether the current hole replaces the pick
  always_comb begin
    fits      = tap.gap_ok && (tap.gap_len >= need);
    take      = 1'b0;
    take_wrap = 1'b0;
    unique case (policy)
      POL_FIRST: take = fits && !found_r;
      POL_NEXT: begin
        take      = fits && !found_r && (hidx_r >= rover);
        take_wrap = fits && !wfound_r && (hidx_r < rover);
      end
      POL_BEST:  take = fits && (!found_r || tap.gap_len < plen_r);
      POL_WORST: take = fits && (!found_r || tap.gap_len > plen_r);
      default:   take = 1'b0;
    endcase
  end

  // Advance one position per step
  always_comb begin
    pos_nxt = pos_r;       hidx_nxt = hidx_r;
    found_nxt = found_r;   pstart_nxt = pstart_r; plen_nxt = plen_r;
    pslot_nxt = pslot_r;   phidx_nxt = phidx_r;
    wfound_nxt = wfound_r; wstart_nxt = wstart_r;
    wslot_nxt = wslot_r;   whidx_nxt = whidx_r;
    vslot_nxt = vslot_r;   vowner_nxt = vowner_r;
    vbase_nxt = vbase_r;   vlen_nxt = vlen_r;
    if (start) begin
      pos_nxt    = '0;
      hidx_nxt   = '0;
      found_nxt  = 1'b0;
      wfound_nxt = 1'b0;
      vslot_nxt  = '0;
    end else if (step) begin
      pos_nxt = pos_r + IDX_W'(1);
      if (tap.gap_ok) begin
        hidx_nxt = hidx_r + HOLE_W'(1);
      end
      if (take) begin
        found_nxt  = 1'b1;
        pstart_nxt = tap.gap_start;
        plen_nxt   = tap.gap_len;
        pslot_nxt  = pos_r;
        phidx_nxt  = hidx_r;
      end
      if (take_wrap) begin
        wfound_nxt = 1'b1;
        wstart_nxt = tap.gap_start;
        wslot_nxt  = pos_r;
        whidx_nxt  = hidx_r;
      end
      if (tap.is_seg && tap.victim) begin
        vslot_nxt  = pos_r;
        vowner_nxt = tap.seg_owner;
        vbase_nxt  = tap.seg_base;
        vlen_nxt   = tap.seg_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;       hidx_r <= hidx_nxt;
    found_r <= found_nxt;   pstart_r <= pstart_nxt; plen_r <= plen_nxt;
    pslot_r <= pslot_nxt;   phidx_r <= phidx_nxt;
    wfound_r <= wfound_nxt; wstart_r <= wstart_nxt;
    wslot_r <= wslot_nxt;   whidx_r <= whidx_nxt;
    vslot_r <= vslot_nxt;   vowner_r <= vowner_nxt;
    vbase_r <= vbase_nxt;   vlen_r <= vlen_nxt;
  end

  // Fall back to the wrapped part of a roving search
  always_comb begin
    res.holes        = hidx_r;
    res.victim_slot  = vslot_r;
    res.victim_owner = vowner_r;
    res.victim_base  = vbase_r;
    res.victim_len   = vlen_r;
    if (found_r || policy != POL_NEXT) begin
      res.found = found_r;
      res.start = pstart_r;
      res.slot  = pslot_r;
      res.hidx  = phidx_r;
    end else begin
      res.found = wfound_r;
      res.start = wstart_r;
      res.slot  = wslot_r;
      res.hidx  = whidx_r;
    end
  end

endmodule

// ===== rtl/contiguous_fit_allocator_top.sv =====
// Top level of the contiguous fit allocator: cell chain, selector and sequencer.
//
//   channel  | direction | handshake              | payload
//   in_      | slave     | in_tvalid/in_tready    | owner_id, request_units
//   out_     | master    | out_tvalid/out_tready  | outcome .. used_units, tlast
//   cfg      | APB       | psel/penable/pready    | fit_policy, memory_size
//
// Every scan of the segment chain is a load, then one position a cycle through
// the selector, then a decision. A reject is reported after one scan and a
// placement after a second one. Each eviction adds a rescan plus its report
// and retry decisions.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// A full output register holds the sequencer in any decision cycle.
`timescale 1ns / 1ps
module contiguous_fit_allocator_top
  import cfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // tdata: owner_id[7:0], request_units[19:8]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // tdata: outcome[1:0], subject_id[9:2], base_address[21:10],
  //        resident_count[27:22], hole_count[33:28], used_units[45:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  localparam logic [1:0] PH_FIRST   = 2'd0;
  localparam logic [1:0] PH_RETRY   = 2'd1;
  localparam logic [1:0] PH_PLACED  = 2'd2;
  localparam logic [1:0] PH_EVICTED = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ADDR_W-1:0] need_r, need_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] used_r, used_nxt;
  logic [HOLE_W-1:0] rover_r, rover_nxt;
  logic [CNT_W-1:0]  evn_r, evn_nxt;
  logic [ADDR_W-1:0] pbase_r, pbase_nxt;
  logic [ID_W-1:0]   evid_r, evid_nxt;
  logic [ADDR_W-1:0] evbase_r, evbase_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [1:0]        policy_r;
  logic [ADDR_W-1:0] mem_r;
  logic              ovalid_r, ovalid_nxt;
  logic [47:0]       odata_r, odata_nxt;
  logic              olast_r, olast_nxt;

  ctrl_t ctrl;
  sel_t  sel;
  seg_t  segs [NUM_CELLS];
  tap_t  taps [NUM_CELLS];
  logic  out_free;
  logic  cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MEMSIZE) begin
      prdata = {20'd0, mem_r};
    end else begin
      prdata = {30'd0, policy_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
      mem_r    <= MEMORY_RESET;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_POLICY) begin
        policy_r <= pwdata[1:0];
      end else begin
        mem_r <= pwdata[ADDR_W-1:0];
      end
    end
  end

  // Cell chain
  genvar g;
  generate
    for (g = 0; g < NUM_CELLS; g++) begin : g_cell
      seg_t lseg, rseg;
      tap_t rtap;
      if (g == 0) begin : g_first
        assign lseg = '0;
      end else begin : g_mid
        assign lseg = segs[g-1];
      end
      if (g == NUM_CELLS - 1) begin : g_last
        assign rseg = '0;
        assign rtap = '0;
      end else begin : g_inner
        assign rseg = segs[g+1];
        assign rtap = taps[g+1];
      end
      cfa_cell u_cell (
        .clk       (clk),
        .cell_idx  (IDX_W'(g)),
        .ctrl      (ctrl),
        .left_seg  (lseg),
        .right_seg (rseg),
        .right_tap (rtap),
        .seg_q     (segs[g]),
        .tap_q     (taps[g])
      );
    end
  endgenerate

  cfa_select u_select (
    .clk    (clk),
    .start  (state_r == ST_LOAD),
    .step   (state_r == ST_SCAN),
    .policy (policy_r),
    .need   (need_r),
    .rover  (rover_r),
    .tap    (taps[0]),
    .res    (sel)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_free   = !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;  phase_nxt = phase_r;
    id_nxt     = id_r;     need_nxt  = need_r;
    count_nxt  = count_r;  used_nxt  = used_r;
    rover_nxt  = rover_r;  evn_nxt   = evn_r;
    pbase_nxt  = pbase_r;  evid_nxt  = evid_r;
    evbase_nxt = evbase_r; scan_nxt  = scan_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    ctrl          = '0;
    ctrl.op       = OP_HOLD;
    ctrl.count    = count_r;
    ctrl.mem_size = mem_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          id_nxt    = in_tdata[7:0];
          need_nxt  = in_tdata[19:8];
          evn_nxt   = '0;
          phase_nxt = PH_FIRST;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctrl.op   = OP_LOAD;
        scan_nxt  = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        ctrl.op  = OP_SHIFT;
        scan_nxt = scan_r + IDX_W'(1);
        if (scan_r == IDX_W'(NUM_CELLS - 1)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          if (phase_r == PH_PLACED) begin
            // Report the placement
            ovalid_nxt = 1'b1;
            odata_nxt  = {2'b00, used_r, sel.holes, count_r, pbase_r, id_r, OUT_PLACED};
            olast_nxt  = 1'b1;
            state_nxt  = ST_IDLE;
          end else if (phase_r == PH_EVICTED) begin
            // Report the eviction, then retry on the same scan
            ovalid_nxt = 1'b1;
            odata_nxt  = {2'b00, used_r, sel.holes, count_r, evbase_r, evid_r, OUT_EVICTED};
            olast_nxt  = 1'b0;
            phase_nxt  = PH_RETRY;
          end else if (phase_r == PH_FIRST && (need_r == '0 || need_r > mem_r)) begin
            // Reject a zero or oversized request
            ovalid_nxt = 1'b1;
            odata_nxt  = {2'b00, used_r, sel.holes, count_r, {ADDR_W{1'b0}}, id_r,
                          OUT_REJECTED};
            olast_nxt  = 1'b1;
            state_nxt  = ST_IDLE;
          end else if (count_r < CNT_W'(MAX_SEGMENTS) && sel.found) begin
            // Place at the chosen hole
            ctrl.op            = OP_INSERT;
            ctrl.slot          = sel.slot;
            ctrl.new_seg.base  = sel.start;
            ctrl.new_seg.len   = need_r;
            ctrl.new_seg.owner = id_r;
            ctrl.new_seg.age   = count_r[AGE_W-1:0];
            count_nxt = count_r + CNT_W'(1);
            used_nxt  = used_r + need_r;
            if (policy_r == POL_NEXT) begin
              rover_nxt = sel.hidx;
            end
            pbase_nxt = sel.start;
            phase_nxt = PH_PLACED;
            state_nxt = ST_LOAD;
          end else if (count_r == '0 || evn_r >= CNT_W'(MAX_SEGMENTS)) begin
            // Nothing left to evict
            ovalid_nxt = 1'b1;
            odata_nxt  = {2'b00, used_r, sel.holes, count_r, {ADDR_W{1'b0}}, id_r,
                          OUT_REJECTED};
            olast_nxt  = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            // Evict the oldest-loaded segment
            ctrl.op    = OP_REMOVE;
            ctrl.slot  = sel.victim_slot;
            count_nxt  = count_r - CNT_W'(1);
            used_nxt   = used_r - sel.victim_len;
            rover_nxt  = '0;
            evn_nxt    = evn_r + CNT_W'(1);
            evid_nxt   = sel.victim_owner;
            evbase_nxt = sel.victim_base;
            phase_nxt  = PH_EVICTED;
            state_nxt  = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_FIRST;
      count_r  <= '0;
      used_r   <= '0;
      rover_r  <= '0;
      evn_r    <= '0;
      scan_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      used_r   <= used_nxt;
      rover_r  <= rover_nxt;
      evn_r    <= evn_nxt;
      scan_r   <= scan_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    need_r   <= need_nxt;
    pbase_r  <= pbase_nxt;
    evid_r   <= evid_nxt;
    evbase_r <= evbase_nxt;
    odata_r  <= odata_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

// ===== rtl/cfa_checker.sv =====
// Port-level checker of the contiguous fit allocator and its bind.
`timescale 1ns / 1ps
module cfa_checker
  import cfa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast,
  input logic        pready
);

  // Hold a stalled result transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Evictions never end a run; placements and rejects always do
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[1:0] != OUT_EVICTED)))
    else $error("tlast does not match outcome");

  // Only defined outcomes appear
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == OUT_PLACED || out_tdata[1:0] == OUT_EVICTED ||
                    out_tdata[1:0] == OUT_REJECTED))
    else $error("undefined outcome");

  // Residents never exceed the table and rejects carry base zero
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[27:22] <= 6'(MAX_SEGMENTS) &&
                   (out_tdata[1:0] != OUT_REJECTED || out_tdata[21:10] == '0))
    else $error("bad resident count or reject base");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind contiguous_fit_allocator_top cfa_checker u_cfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .pready     (pready)
);
